[src/ehte_pkg.sv]
// ehte_pkg: shared types and constants of the extendible hash table engine
`timescale 1ns / 1ps
package ehte_pkg;

    localparam int SHARD_SLOTS = 256;
    localparam int MAX_SHARDS  = 16;
    localparam int MAX_DEPTH   = 4;
    localparam int KEY_BYTES   = 16;
    localparam int VALUE_BYTES = 8;

    localparam int SLOT_BITS  = $clog2(SHARD_SLOTS);
    localparam int SHARD_BITS = $clog2(MAX_SHARDS);
    localparam int ADDR_BITS  = SLOT_BITS + SHARD_BITS;
    localparam int TOTAL_SLOTS = SHARD_SLOTS * MAX_SHARDS;
    localparam int CNT_W      = $clog2(SHARD_SLOTS + 1);
    localparam int DEPTH_W    = 3;
    localparam int DIR_ENTRIES = 1 << MAX_DEPTH;
    localparam int THRESH     = (SHARD_SLOTS * 3 + 3) / 4;
    localparam int TAIL_BYTES = KEY_BYTES - 8;
    localparam logic [63:0] TAIL_MASK =
        (TAIL_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * TAIL_BYTES)) - 64'd1);

    localparam logic [1:0] OP_PUT = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FLAG_EMPTY    = 2'd0,
        FLAG_OCCUPIED = 2'd1,
        FLAG_TOMBSTONE = 2'd2
    } t_flag;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ROUTE, S_LOAD, S_IREAD, S_ICHK, S_IWRITE,
        S_FREAD, S_FCHK, S_SPLIT, S_CLR, S_SREAD, S_SCHK, S_SFIN, S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key_fingerprint;
        logic [63:0] key_tail;
        logic [63:0] value_in;
        logic [3:0]  value_length_in;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value_out;
        logic [3:0]  value_length_out;
        logic [12:0] total_entries;
        logic [4:0]  shards_in_use;
        logic [2:0]  directory_depth;
    } t_rsp;

    typedef struct packed {
        logic [63:0] fp;
        logic [63:0] tail;
        logic [63:0] val;
        logic [3:0]  len;
    } t_slot;

endpackage

[src/extendible_hash_table_engine.sv]
// extendible_hash_table_engine: key-value table with extendible hashing over linear-probed shards
`timescale 1ns / 1ps
// usage
//   request beat: drive i_req and raise start; the beat is taken at an edge where
//   start is high and busy is low. busy stays high until the result is shown.
//   result beat: o_rsp is valid for exactly one cycle while o_done is high; the
//   receiver cannot stall it, so it must take the beat in that cycle.
//   config: i_cfg_we with i_cfg_wdata sets the max value length (reset 8); write
//   only while busy is low.
// steps (accept to next possible accept)
//   a rejected put or unknown op goes straight to the result beat; get and
//   delete route and then probe, a plain put also checks the load and writes;
//   each probed slot takes one read of the slot rams and one compare.
//   a put that splits its shard also does the split, clears the two new shards,
//   scans each old slot, probes and writes each rehashed entry, and then updates
//   the directory and re-routes; the single slot-ram port and shared compare
//   set the pace.
// reset
//   i_rst_n low (synchronous) empties the table; afterwards a clearing pass over
//   all TOTAL_SLOTS (4096) slots sweeps the slot flag ram with busy high.
module extendible_hash_table_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ehte_pkg::t_req i_req,
    output logic           o_done,
    output ehte_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_wdata
);
    import ehte_pkg::*;

    t_state r_state, n_state;
    logic [ADDR_BITS-1:0] r_clr, n_clr;
    t_req r_req, n_req;
    // item under insertion or lookup
    logic [63:0] r_cfp, n_cfp, r_ctail, n_ctail, r_cval, n_cval;
    logic [3:0]  r_clen, n_clen;
    logic [SHARD_BITS-1:0] r_sh, n_sh, r_old, n_old, r_a, n_a, r_b, n_b;
    logic [SLOT_BITS-1:0]  r_idx, n_idx, r_first, n_first, r_pos, n_pos;
    logic [SLOT_BITS-1:0]  r_scan, n_scan;
    logic [CNT_W-1:0]      r_n, n_n;
    logic r_first_v, n_first_v, r_match, n_match, r_use_tomb, n_use_tomb;
    logic r_rehash, n_rehash, r_split_done, n_split_done;
    logic [DEPTH_W-1:0] r_nd, n_nd, r_gd, n_gd;
    // directory and shard bookkeeping
    logic [SHARD_BITS-1:0] r_dir [DIR_ENTRIES];
    logic [SHARD_BITS-1:0] n_dir [DIR_ENTRIES];
    logic [MAX_SHARDS-1:0] r_inuse, n_inuse;
    logic [DEPTH_W-1:0] r_ldep [MAX_SHARDS];
    logic [DEPTH_W-1:0] n_ldep [MAX_SHARDS];
    logic [CNT_W-1:0] r_cnt [MAX_SHARDS];
    logic [CNT_W-1:0] n_cnt [MAX_SHARDS];
    logic [CNT_W-1:0] r_tomb [MAX_SHARDS];
    logic [CNT_W-1:0] n_tomb [MAX_SHARDS];
    logic [12:0] r_total, n_total;
    logic [4:0]  r_used, n_used;
    // result
    t_status r_status, n_status;
    logic [63:0] r_vout, n_vout;
    logic [3:0]  r_vlen, n_vlen, r_maxlen, n_maxlen;

    // slot rams
    logic                 flag_we, data_we;
    logic [ADDR_BITS-1:0] waddr, raddr;
    logic [1:0]           flag_wdata, flag_rdata;
    t_slot                data_wdata, data_rdata;

    ehte_ram #(.WIDTH(2), .DEPTH(TOTAL_SLOTS)) u_flags (
        .i_clk(i_clk), .i_we(flag_we), .i_waddr(waddr), .i_wdata(flag_wdata),
        .i_raddr(raddr), .o_rdata(flag_rdata)
    );
    ehte_ram #(.WIDTH($bits(t_slot)), .DEPTH(TOTAL_SLOTS)) u_data (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(waddr), .i_wdata(data_wdata),
        .i_raddr(raddr), .o_rdata(data_rdata)
    );

    // helpers
    logic [3:0]  lim;
    logic [63:0] vmask;
    logic [SHARD_BITS-1:0] route_sh, free_a, free_b;
    logic [MAX_DEPTH-1:0]  dir_idx;
    logic free_av, free_bv, key_hit, last_probe;
    logic [6:0] split_bit;

    assign lim = (r_maxlen < 4'(VALUE_BYTES)) ? r_maxlen : 4'(VALUE_BYTES);

    always_comb begin
        vmask = '0;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < i_req.value_length_in) begin
                vmask[8*k +: 8] = 8'hff;
            end
        end
    end

    // top global-depth bits of the fingerprint pick the directory entry
    assign dir_idx  = r_req.key_fingerprint[63 -: MAX_DEPTH] >> (MAX_DEPTH - int'(r_gd));
    assign route_sh = (r_gd == '0) ? '0 : r_dir[dir_idx];

    // two lowest free pool indices
    always_comb begin
        free_a = '0; free_b = '0; free_av = 1'b0; free_bv = 1'b0;
        for (int i = 0; i < MAX_SHARDS; i++) begin
            if (!r_inuse[i]) begin
                if (!free_av) begin
                    free_a = SHARD_BITS'(i); free_av = 1'b1;
                end else if (!free_bv) begin
                    free_b = SHARD_BITS'(i); free_bv = 1'b1;
                end
            end
        end
    end

    assign key_hit    = (flag_rdata == FLAG_OCCUPIED) && (data_rdata.fp == r_cfp)
                        && (data_rdata.tail == r_ctail);
    assign last_probe = (r_n == CNT_W'(SHARD_SLOTS - 1));
    assign split_bit  = 7'd64 - 7'(r_nd);

    always_comb begin
        raddr = {r_sh, r_idx};
        if (r_state == S_SREAD) begin
            raddr = {r_old, r_scan};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_clr    <= '0;
            r_gd     <= '0;
            r_inuse  <= MAX_SHARDS'(1);
            r_total  <= '0;
            r_used   <= 5'd1;
            r_maxlen <= 4'd8;
            for (int i = 0; i < DIR_ENTRIES; i++) r_dir[i] <= '0;
            for (int i = 0; i < MAX_SHARDS; i++) begin
                r_ldep[i] <= '0; r_cnt[i] <= '0; r_tomb[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_gd     <= n_gd;
            r_inuse  <= n_inuse;
            r_total  <= n_total;
            r_used   <= n_used;
            r_maxlen <= n_maxlen;
            r_dir    <= n_dir;
            r_ldep   <= n_ldep;
            r_cnt    <= n_cnt;
            r_tomb   <= n_tomb;
        end
        r_req <= n_req; r_cfp <= n_cfp; r_ctail <= n_ctail; r_cval <= n_cval;
        r_clen <= n_clen; r_sh <= n_sh; r_old <= n_old; r_a <= n_a; r_b <= n_b;
        r_idx <= n_idx; r_first <= n_first; r_pos <= n_pos; r_scan <= n_scan;
        r_n <= n_n; r_first_v <= n_first_v; r_match <= n_match;
        r_use_tomb <= n_use_tomb; r_rehash <= n_rehash; r_split_done <= n_split_done;
        r_nd <= n_nd; r_status <= n_status; r_vout <= n_vout; r_vlen <= n_vlen;
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_req = r_req;
        n_cfp = r_cfp; n_ctail = r_ctail; n_cval = r_cval; n_clen = r_clen;
        n_sh = r_sh; n_old = r_old; n_a = r_a; n_b = r_b;
        n_idx = r_idx; n_first = r_first; n_pos = r_pos; n_scan = r_scan; n_n = r_n;
        n_first_v = r_first_v; n_match = r_match; n_use_tomb = r_use_tomb;
        n_rehash = r_rehash; n_split_done = r_split_done; n_nd = r_nd; n_gd = r_gd;
        n_dir = r_dir; n_inuse = r_inuse; n_ldep = r_ldep; n_cnt = r_cnt; n_tomb = r_tomb;
        n_total = r_total; n_used = r_used;
        n_status = r_status; n_vout = r_vout; n_vlen = r_vlen;
        n_maxlen = i_cfg_we ? i_cfg_wdata : r_maxlen;
        flag_we = 1'b0; data_we = 1'b0;
        waddr = {r_sh, r_pos};
        flag_wdata = FLAG_EMPTY;
        data_wdata = '{fp: r_cfp, tail: r_ctail, val: r_cval, len: r_clen};

        case (r_state)
            // clearing pass over the whole flag ram after reset
            S_INIT: begin
                flag_we = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_BITS'(TOTAL_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_req.key_tail = i_req.key_tail & TAIL_MASK;
                    n_req.value_in = i_req.value_in & vmask;
                    n_vout = '0; n_vlen = '0;
                    n_split_done = 1'b0;
                    if (i_req.operation == OP_PUT && i_req.value_length_in > lim) begin
                        n_status = ST_TOO_LONG; n_state = S_RESP;
                    end else if (i_req.operation != OP_PUT && i_req.operation != OP_GET
                                 && i_req.operation != OP_DEL) begin
                        n_status = ST_NOT_FOUND; n_state = S_RESP;
                    end else begin
                        n_state = S_ROUTE;
                    end
                end
            end
            S_ROUTE: begin
                n_sh = route_sh;
                n_idx = r_req.key_fingerprint[SLOT_BITS-1:0];
                n_n = '0; n_first_v = 1'b0; n_rehash = 1'b0;
                n_cfp = r_req.key_fingerprint; n_ctail = r_req.key_tail;
                n_cval = r_req.value_in; n_clen = r_req.value_length_in;
                n_state = (r_req.operation == OP_PUT) ? S_LOAD : S_FREAD;
            end
            // load check before insert, split at most once per put
            S_LOAD: begin
                if (!r_split_done && (r_cnt[r_sh] + r_tomb[r_sh]) >= CNT_W'(THRESH)) begin
                    n_state = S_SPLIT;
                end else begin
                    n_state = S_IREAD;
                end
            end
            S_IREAD: n_state = S_ICHK;
            S_ICHK: begin
                n_idx = r_idx + 1'b1;
                n_n = r_n + 1'b1;
                n_state = S_IREAD;
                if (flag_rdata == FLAG_EMPTY) begin
                    n_match = 1'b0; n_use_tomb = r_first_v;
                    n_pos = r_first_v ? r_first : r_idx;
                    n_state = S_IWRITE;
                end else if (key_hit) begin
                    n_match = 1'b1; n_use_tomb = 1'b0; n_pos = r_idx;
                    n_state = S_IWRITE;
                end else begin
                    if (flag_rdata == FLAG_TOMBSTONE && !r_first_v) begin
                        n_first_v = 1'b1; n_first = r_idx;
                    end
                    if (last_probe) begin
                        if (r_first_v || flag_rdata == FLAG_TOMBSTONE) begin
                            n_match = 1'b0; n_use_tomb = 1'b1;
                            n_pos = r_first_v ? r_first : r_idx;
                            n_state = S_IWRITE;
                        end else begin
                            n_status = ST_FULL; n_state = S_RESP;
                        end
                    end
                end
            end
            S_IWRITE: begin
                flag_we = 1'b1; data_we = 1'b1;
                flag_wdata = FLAG_OCCUPIED;
                if (!r_match) begin
                    n_cnt[r_sh] = r_cnt[r_sh] + 1'b1;
                    if (r_use_tomb && r_tomb[r_sh] != '0) begin
                        n_tomb[r_sh] = r_tomb[r_sh] - 1'b1;
                    end
                end
                if (r_rehash) begin
                    n_scan = r_scan + 1'b1;
                    n_state = (r_scan == SLOT_BITS'(SHARD_SLOTS - 1)) ? S_SFIN : S_SREAD;
                end else begin
                    if (!r_match) n_total = r_total + 1'b1;
                    n_status = ST_OK; n_state = S_RESP;
                end
            end
            S_FREAD: n_state = S_FCHK;
            S_FCHK: begin
                n_idx = r_idx + 1'b1;
                n_n = r_n + 1'b1;
                n_state = S_FREAD;
                if (flag_rdata == FLAG_EMPTY) begin
                    n_status = ST_NOT_FOUND; n_state = S_RESP;
                end else if (key_hit) begin
                    n_status = ST_OK; n_state = S_RESP;
                    if (r_req.operation == OP_GET) begin
                        n_vout = data_rdata.val; n_vlen = data_rdata.len;
                    end else begin
                        flag_we = 1'b1; waddr = {r_sh, r_idx};
                        flag_wdata = FLAG_TOMBSTONE;
                        if (r_cnt[r_sh] != '0) n_cnt[r_sh] = r_cnt[r_sh] - 1'b1;
                        n_tomb[r_sh] = r_tomb[r_sh] + 1'b1;
                        n_total = r_total - 1'b1;
                    end
                end else if (last_probe) begin
                    n_status = ST_NOT_FOUND; n_state = S_RESP;
                end
            end
            S_SPLIT: begin
                if (int'(r_ldep[r_sh]) + 1 > MAX_DEPTH || !free_bv) begin
                    n_status = ST_FULL; n_state = S_RESP;
                end else begin
                    n_old = r_sh; n_a = free_a; n_b = free_b;
                    n_nd = r_ldep[r_sh] + 1'b1;
                    if (r_ldep[r_sh] >= r_gd) begin
                        // double the directory, each entry copied to its two children
                        for (int j = 0; j < DIR_ENTRIES; j++) begin
                            if ((j >> 1) < (1 << int'(r_gd))) n_dir[j] = r_dir[j >> 1];
                        end
                        n_gd = r_gd + 1'b1;
                    end
                    n_inuse[free_a] = 1'b1; n_inuse[free_b] = 1'b1;
                    n_ldep[free_a] = r_ldep[r_sh] + 1'b1;
                    n_ldep[free_b] = r_ldep[r_sh] + 1'b1;
                    n_cnt[free_a] = '0; n_cnt[free_b] = '0;
                    n_tomb[free_a] = '0; n_tomb[free_b] = '0;
                    n_used = r_used + 5'd2;
                    n_clr = '0;
                    n_state = S_CLR;
                end
            end
            // sweep flags of both new shards
            S_CLR: begin
                flag_we = 1'b1;
                waddr = {(r_clr[SLOT_BITS] ? r_b : r_a), r_clr[SLOT_BITS-1:0]};
                n_clr = r_clr + 1'b1;
                if (r_clr[SLOT_BITS:0] == {1'b1, {SLOT_BITS{1'b1}}}) begin
                    n_scan = '0; n_state = S_SREAD;
                end
            end
            S_SREAD: n_state = S_SCHK;
            S_SCHK: begin
                if (flag_rdata == FLAG_OCCUPIED) begin
                    n_cfp = data_rdata.fp; n_ctail = data_rdata.tail;
                    n_cval = data_rdata.val; n_clen = data_rdata.len;
                    n_sh = data_rdata.fp[split_bit[5:0]] ? r_b : r_a;
                    n_idx = data_rdata.fp[SLOT_BITS-1:0];
                    n_n = '0; n_first_v = 1'b0; n_rehash = 1'b1;
                    n_state = S_IREAD;
                end else begin
                    n_scan = r_scan + 1'b1;
                    n_state = (r_scan == SLOT_BITS'(SHARD_SLOTS - 1)) ? S_SFIN : S_SREAD;
                end
            end
            S_SFIN: begin
                for (int j = 0; j < DIR_ENTRIES; j++) begin
                    if (j < (1 << int'(r_gd)) && r_dir[j] == r_old) begin
                        n_dir[j] = ((j >> (int'(r_gd) - int'(r_nd))) & 1) != 0 ? r_b : r_a;
                    end
                end
                n_inuse[r_old] = 1'b0;
                n_ldep[r_old] = '0; n_cnt[r_old] = '0; n_tomb[r_old] = '0;
                n_used = r_used - 5'd1;
                n_split_done = 1'b1;
                n_state = S_ROUTE;
            end
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);
    assign o_rsp  = '{status: r_status, value_out: r_vout, value_length_out: r_vlen,
                      total_entries: r_total, shards_in_use: r_used,
                      directory_depth: r_gd};

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result beat outside busy window");
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == 5'($countones(r_inuse))) else $error("shard count mismatch");
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_gd) <= MAX_DEPTH) else $error("directory depth overflow");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
`endif
endmodule

[src/ehte_ram.sv]
// ehte_ram: generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module ehte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
